// ===== hw/rtl/pfte_pkg.sv =====
// Shared types and constants for the programmable FSM table engine.
// Used by pfte_edge_store and programmable_fsm_table_engine; no dependencies.
package pfte_pkg;

  localparam int NUM_STATES  = 16;
  localparam int MAX_EDGES   = 8;
  localparam int SYMBOL_BITS = 8;

  localparam int STATE_W = $clog2(NUM_STATES);
  localparam int SLOT_W  = $clog2(MAX_EDGES);
  localparam int ADDR_W  = STATE_W + SLOT_W;
  localparam int LIM_W   = $clog2(MAX_EDGES + 1);

  typedef enum logic [2:0] {
    CMD_STEP      = 3'd0,
    CMD_ADD_STATE = 3'd1,
    CMD_DEL_STATE = 3'd2,
    CMD_ADD_EDGE  = 3'd3,
    CMD_DEL_EDGE  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOSTATE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_COMMIT,
    S_RESP
  } fsm_t;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] key;
    logic [STATE_W-1:0]     dest;
  } edge_t;

  typedef struct packed {
    logic                rd_vld;
    logic                vld;
    edge_t               data;
  } edge_rd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic               vld_set;
    logic [ADDR_W-1:0]  wr_addr;
    edge_t              wr_data;
    logic               vld_clr;
    logic [ADDR_W-1:0]  clr_addr;
    logic               row_clr;
    logic [STATE_W-1:0] row;
  } edge_ctl_t;

endpackage

// ===== hw/rtl/pfte_edge_store.sv =====
// Edge slot store: key/destination memory with registered read, plus valid bits.
// Depends on pfte_pkg.
module pfte_edge_store (
  input  logic                clk,
  input  logic                rst_n,
  input  pfte_pkg::edge_ctl_t ctl,
  output pfte_pkg::edge_rd_t  rd
);
  import pfte_pkg::*;

  localparam int DEPTH = NUM_STATES * MAX_EDGES;

  edge_t                mem [DEPTH];
  logic [DEPTH-1:0]     vld_r;
  edge_t                rd_data_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    rd_data_r <= mem[ctl.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[ctl.rd_addr];
      if (ctl.row_clr) begin
        for (int j = 0; j < MAX_EDGES; j++) begin
          vld_r[{ctl.row, SLOT_W'(j)}] <= 1'b0;
        end
      end
      if (ctl.vld_clr) begin
        vld_r[ctl.clr_addr] <= 1'b0;
      end
      if (ctl.vld_set) begin
        vld_r[ctl.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd.rd_vld = 1'b1;
  assign rd.vld    = rd_vld_r;
  assign rd.data   = rd_data_r;

endmodule

// ===== hw/rtl/programmable_fsm_table_engine.sv =====
// Top level of the programmable FSM table engine: command sequencer, state table.
// Depends on pfte_pkg and pfte_edge_store.
//
//   channel  ports                                                  dir
//   in       in_valid/in_ready, command, target_state, symbol,      in
//            next_state, capacity
//   out      out_valid/out_ready, cur_state, status                 out
//
// Add/delete state, unknown commands and edits or steps on an absent state go
// from the check state straight to the result beat. Step and transition edits scan
// the state's slots through one registered memory read port and one comparator,
// one slot a cycle; a key match ends a step or add early, and add transition
// without a key match passes through a commit state. Idle follows each beat.
// Synchronous reset clears all states, valid bits and the current state at once.
// A beat is taken only when idle; a result held by out_ready stalls the input.
module programmable_fsm_table_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_command,
  input  logic [3:0]                   in_target_state,
  input  logic [7:0]                   in_symbol,
  input  logic [3:0]                   in_next_state,
  input  logic [3:0]                   in_capacity,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [3:0]                   out_cur_state,
  output logic [1:0]                   out_status
);
  import pfte_pkg::*;

  fsm_t                    state_r, state_nxt;
  cmd_t                    cmd_r, cmd_nxt;
  logic [STATE_W-1:0]      tgt_r, tgt_nxt;
  logic [SYMBOL_BITS-1:0]  sym_r, sym_nxt;
  logic [STATE_W-1:0]      dst_r, dst_nxt;
  logic [3:0]              cap_r, cap_nxt;
  logic [STATE_W-1:0]      now_r, now_nxt;
  logic [SLOT_W-1:0]       k_r, k_nxt;
  logic [LIM_W-1:0]        used_r, used_nxt;
  logic                    free_hit_r, free_hit_nxt;
  logic [SLOT_W-1:0]       free_k_r, free_k_nxt;
  status_t                 status_r, status_nxt;
  logic [NUM_STATES-1:0]   present_r, present_nxt;
  logic [LIM_W-1:0]        limit_r [NUM_STATES];
  logic [LIM_W-1:0]        limit_nxt [NUM_STATES];

  edge_ctl_t               ctl;
  edge_rd_t                rd;
  logic [STATE_W-1:0]      base;
  logic [LIM_W-1:0]        cap_sat;
  logic [SYMBOL_BITS-1:0]  cmp_a, cmp_b;
  logic                    hit;
  logic                    last;

  pfte_edge_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .rd    (rd)
  );

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = (state_r == S_RESP);
  assign out_cur_state = now_r;
  assign out_status    = status_r;

  assign base = (cmd_r == CMD_STEP) ? now_r : tgt_r;
  assign last = (k_r == SLOT_W'(MAX_EDGES - 1));

  always_comb begin
    if (cap_r == 4'd0) begin
      cap_sat = LIM_W'(1);
    end else if (32'(cap_r) > MAX_EDGES) begin
      cap_sat = LIM_W'(MAX_EDGES);
    end else begin
      cap_sat = LIM_W'(cap_r);
    end
  end

  // shared comparator: key match for step/add, destination match for delete
  always_comb begin
    if (cmd_r == CMD_DEL_EDGE) begin
      cmp_a = SYMBOL_BITS'(rd.data.dest);
      cmp_b = SYMBOL_BITS'(dst_r);
    end else begin
      cmp_a = rd.data.key;
      cmp_b = sym_r;
    end
    hit = rd.rd_vld && rd.vld && (cmp_a == cmp_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      now_r     <= '0;
      present_r <= '0;
      for (int i = 0; i < NUM_STATES; i++) begin
        limit_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      now_r     <= now_nxt;
      present_r <= present_nxt;
      limit_r   <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    tgt_r      <= tgt_nxt;
    sym_r      <= sym_nxt;
    dst_r      <= dst_nxt;
    cap_r      <= cap_nxt;
    k_r        <= k_nxt;
    used_r     <= used_nxt;
    free_hit_r <= free_hit_nxt;
    free_k_r   <= free_k_nxt;
    status_r   <= status_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    tgt_nxt      = tgt_r;
    sym_nxt      = sym_r;
    dst_nxt      = dst_r;
    cap_nxt      = cap_r;
    now_nxt      = now_r;
    k_nxt        = k_r;
    used_nxt     = used_r;
    free_hit_nxt = free_hit_r;
    free_k_nxt   = free_k_r;
    status_nxt   = status_r;
    present_nxt  = present_r;
    limit_nxt    = limit_r;

    ctl          = '0;
    ctl.rd_addr  = {base, k_r + SLOT_W'(1)};
    ctl.wr_addr  = {base, k_r};
    ctl.wr_data  = '{key: sym_r, dest: dst_r};
    ctl.clr_addr = {base, k_r};
    ctl.row      = tgt_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = cmd_t'(in_command);
          tgt_nxt    = in_target_state;
          sym_nxt    = in_symbol[SYMBOL_BITS-1:0];
          dst_nxt    = in_next_state;
          cap_nxt    = in_capacity;
          status_nxt = ST_OK;
          state_nxt  = S_CHECK;
        end
      end

      S_CHECK: begin
        k_nxt        = '0;
        used_nxt     = '0;
        free_hit_nxt = 1'b0;
        free_k_nxt   = '0;
        ctl.rd_addr  = {base, SLOT_W'(0)};
        state_nxt    = S_RESP;
        unique case (cmd_r) inside
          CMD_STEP: begin
            if (!present_r[now_r]) begin
              now_nxt    = '0;
              status_nxt = ST_NOSTATE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          CMD_ADD_STATE: begin
            if (!present_r[tgt_r]) begin
              present_nxt[tgt_r] = 1'b1;
              limit_nxt[tgt_r]   = cap_sat;
              ctl.row_clr        = 1'b1;
            end
          end
          CMD_DEL_STATE: begin
            present_nxt[tgt_r] = 1'b0;
            limit_nxt[tgt_r]   = '0;
            ctl.row_clr        = 1'b1;
            if (now_r == tgt_r) begin
              now_nxt = '0;
            end
          end
          CMD_ADD_EDGE, CMD_DEL_EDGE: begin
            if (!present_r[tgt_r]) begin
              status_nxt = ST_NOSTATE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end

      S_SCAN: begin
        k_nxt = k_r + SLOT_W'(1);
        unique case (cmd_r)
          CMD_STEP: begin
            if (hit) begin
              now_nxt   = rd.data.dest;
              state_nxt = S_RESP;
            end else if (last) begin
              state_nxt = S_RESP;
            end
          end
          CMD_ADD_EDGE: begin
            if (hit) begin
              ctl.wr_en = 1'b1;
              state_nxt = S_RESP;
            end else begin
              if (rd.vld) begin
                used_nxt = used_r + LIM_W'(1);
              end else if (!free_hit_r) begin
                free_hit_nxt = 1'b1;
                free_k_nxt   = k_r;
              end
              if (last) begin
                state_nxt = S_COMMIT;
              end
            end
          end
          default: begin
            if (hit) begin
              ctl.vld_clr = 1'b1;
            end
            if (last) begin
              state_nxt = S_RESP;
            end
          end
        endcase
      end

      S_COMMIT: begin
        state_nxt = S_RESP;
        if ((used_r >= limit_r[tgt_r]) || !free_hit_r) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.wr_addr = {tgt_r, free_k_r};
          ctl.wr_en   = 1'b1;
          ctl.vld_set = 1'b1;
        end
      end

      S_RESP: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for programmable_fsm_table_engine: a table of directed commands,
// then random edit/step traffic under varying back-pressure, scored against a mirror
// (typed rows: their own expected beat). Depends on pfte_pkg and the engine RTL.
module tb;
  import pfte_pkg::*;

  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;
  localparam int N_DIRECTED       = 27;
  localparam int ITEMS_PER_PHASE  = 325;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int TAIL_CYCLES      = 20;

  typedef struct packed {
    logic [STATE_W-1:0] state;
    status_t            status;
  } outcome_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  tgt;
    logic [7:0]  sym;
    logic [3:0]  dst;
    logic [3:0]  cap;
    logic        typed;
    outcome_t    want;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] in_command;
  logic [3:0] in_target_state;
  logic [7:0] in_symbol;
  logic [3:0] in_next_state;
  logic [3:0] in_capacity;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] out_cur_state;
  logic [1:0] out_status;

  logic     row_typed;
  outcome_t row_want;

  // mirror of the engine's tables
  logic                   fsm_present  [NUM_STATES];
  logic [LIM_W-1:0]       fsm_limit    [NUM_STATES];
  logic                   fsm_slot_vld [NUM_STATES][MAX_EDGES];
  logic [SYMBOL_BITS-1:0] fsm_slot_key [NUM_STATES][MAX_EDGES];
  logic [STATE_W-1:0]     fsm_slot_dst [NUM_STATES][MAX_EDGES];
  logic [STATE_W-1:0]     fsm_now;

  outcome_t pending_outcomes[$];
  outcome_t predicted;
  outcome_t observed;
  outcome_t oldest;
  int       mismatches = 0;
  int       quiet_cycles = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  int       hold_req = 0;

  logic [7:0] symbol_pool [6] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80};

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{CMD_STEP,      4'd0,  8'h00, 4'd0,  4'd0,  1'b1, '{4'd0,  ST_NOSTATE}},
    '{CMD_ADD_EDGE,  4'd0,  8'h00, 4'd0,  4'd0,  1'b1, '{4'd0,  ST_NOSTATE}},
    '{CMD_DEL_EDGE,  4'd15, 8'h00, 4'd15, 4'd0,  1'b1, '{4'd0,  ST_NOSTATE}},
    '{CMD_ADD_STATE, 4'd0,  8'h00, 4'd0,  4'd0,  1'b1, '{4'd0,  ST_OK}},
    '{CMD_ADD_STATE, 4'd15, 8'h00, 4'd0,  4'd8,  1'b1, '{4'd0,  ST_OK}},
    '{CMD_ADD_STATE, 4'd7,  8'h00, 4'd0,  4'd15, 1'b1, '{4'd0,  ST_OK}},
    '{CMD_ADD_EDGE,  4'd0,  8'hFF, 4'd7,  4'd0,  1'b1, '{4'd0,  ST_OK}},
    '{CMD_ADD_EDGE,  4'd0,  8'h00, 4'd15, 4'd0,  1'b1, '{4'd0,  ST_FULL}},
    '{CMD_ADD_EDGE,  4'd0,  8'hFF, 4'd15, 4'd0,  1'b1, '{4'd0,  ST_OK}},
    '{CMD_ADD_STATE, 4'd0,  8'h00, 4'd0,  4'd8,  1'b1, '{4'd0,  ST_OK}},
    '{CMD_ADD_EDGE,  4'd0,  8'h01, 4'd7,  4'd0,  1'b1, '{4'd0,  ST_FULL}},
    '{CMD_STEP,      4'd0,  8'h03, 4'd0,  4'd0,  1'b1, '{4'd0,  ST_OK}},
    '{CMD_STEP,      4'd0,  8'hFF, 4'd0,  4'd0,  1'b1, '{4'd15, ST_OK}},
    '{CMD_ADD_EDGE,  4'd15, 8'hAA, 4'd3,  4'd0,  1'b0, '{4'd0,  ST_OK}},
    '{CMD_ADD_EDGE,  4'd15, 8'h55, 4'd7,  4'd0,  1'b0, '{4'd0,  ST_OK}},
    '{CMD_STEP,      4'd0,  8'hAA, 4'd0,  4'd0,  1'b0, '{4'd0,  ST_OK}},
    '{CMD_STEP,      4'd0,  8'h00, 4'd0,  4'd0,  1'b1, '{4'd0,  ST_NOSTATE}},
    '{CMD_STEP,      4'd0,  8'hFF, 4'd0,  4'd0,  1'b0, '{4'd0,  ST_OK}},
    '{CMD_DEL_EDGE,  4'd15, 8'h00, 4'd3,  4'd0,  1'b0, '{4'd0,  ST_OK}},
    '{CMD_STEP,      4'd0,  8'h55, 4'd0,  4'd0,  1'b0, '{4'd0,  ST_OK}},
    '{CMD_DEL_STATE, 4'd7,  8'h00, 4'd0,  4'd0,  1'b1, '{4'd0,  ST_OK}},
    '{CMD_DEL_STATE, 4'd9,  8'h00, 4'd0,  4'd0,  1'b1, '{4'd0,  ST_OK}},
    '{CMD_RSVD5,     4'd0,  8'h00, 4'd0,  4'd0,  1'b1, '{4'd0,  ST_OK}},
    '{CMD_RSVD7,     4'd15, 8'hFF, 4'd15, 4'd15, 1'b1, '{4'd0,  ST_OK}},
    '{CMD_STEP,      4'd0,  8'hFF, 4'd0,  4'd0,  1'b0, '{4'd0,  ST_OK}},
    '{CMD_STEP,      4'd0,  8'h55, 4'd0,  4'd0,  1'b0, '{4'd0,  ST_OK}},
    '{CMD_STEP,      4'd0,  8'h00, 4'd0,  4'd0,  1'b1, '{4'd0,  ST_NOSTATE}}
  };

  programmable_fsm_table_engine u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_target_state   (in_target_state),
    .in_symbol         (in_symbol),
    .in_next_state     (in_next_state),
    .in_capacity       (in_capacity),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cur_state     (out_cur_state),
    .out_status        (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_mirror();
    for (int s = 0; s < NUM_STATES; s++) begin
      fsm_present[s] = 1'b0;
      fsm_limit[s]   = '0;
      for (int k = 0; k < MAX_EDGES; k++) begin
        fsm_slot_vld[s][k] = 1'b0;
        fsm_slot_key[s][k] = '0;
        fsm_slot_dst[s][k] = '0;
      end
    end
    fsm_now = '0;
  endfunction

  // updates the mirror and returns the beat the engine should emit
  function automatic outcome_t apply_command(input logic [2:0] cmd, input logic [3:0] tgt,
                                             input logic [7:0] sym, input logic [3:0] dst,
                                             input logic [3:0] cap);
    outcome_t           res;
    logic [STATE_W-1:0] from;
    int                 used;
    int                 free_k;
    bit                 done;
    res.status = ST_OK;
    done       = 1'b0;
    used       = 0;
    free_k     = -1;
    case (cmd)
      CMD_STEP: begin
        from = fsm_now;
        if (!fsm_present[from]) begin
          fsm_now    = '0;
          res.status = ST_NOSTATE;
        end else begin
          for (int k = 0; k < MAX_EDGES; k++)
            if (!done && fsm_slot_vld[from][k] && fsm_slot_key[from][k] == sym) begin
              fsm_now = fsm_slot_dst[from][k];
              done    = 1'b1;
            end
        end
      end
      CMD_ADD_STATE: begin
        if (!fsm_present[tgt]) begin
          fsm_present[tgt] = 1'b1;
          fsm_limit[tgt]   = LIM_W'((cap == 0) ? 1 : (cap > MAX_EDGES) ? MAX_EDGES : cap);
          for (int k = 0; k < MAX_EDGES; k++)
            fsm_slot_vld[tgt][k] = 1'b0;
        end
      end
      CMD_DEL_STATE: begin
        fsm_present[tgt] = 1'b0;
        fsm_limit[tgt]   = '0;
        for (int k = 0; k < MAX_EDGES; k++)
          fsm_slot_vld[tgt][k] = 1'b0;
        if (fsm_now == tgt)
          fsm_now = '0;
      end
      CMD_ADD_EDGE: begin
        if (!fsm_present[tgt]) begin
          res.status = ST_NOSTATE;
        end else begin
          for (int k = 0; k < MAX_EDGES; k++)
            if (!done) begin
              if (fsm_slot_vld[tgt][k]) begin
                if (fsm_slot_key[tgt][k] == sym) begin
                  fsm_slot_dst[tgt][k] = dst;
                  done = 1'b1;
                end else begin
                  used++;
                end
              end else if (free_k < 0) begin
                free_k = k;
              end
            end
          if (!done) begin
            if (used >= fsm_limit[tgt] || free_k < 0) begin
              res.status = ST_FULL;
            end else begin
              fsm_slot_vld[tgt][free_k] = 1'b1;
              fsm_slot_key[tgt][free_k] = sym;
              fsm_slot_dst[tgt][free_k] = dst;
            end
          end
        end
      end
      CMD_DEL_EDGE: begin
        if (!fsm_present[tgt]) begin
          res.status = ST_NOSTATE;
        end else begin
          for (int k = 0; k < MAX_EDGES; k++)
            if (fsm_slot_vld[tgt][k] && fsm_slot_dst[tgt][k] == dst)
              fsm_slot_vld[tgt][k] = 1'b0;
        end
      end
      default: ;
    endcase
    res.state = fsm_now;
    return res;
  endfunction

  function automatic void flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
  endfunction

  // scoreboard and watchdog count; outputs scored before the new command is mirrored
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      observed.state  = out_cur_state;
      observed.status = status_t'(out_status);
      if (pending_outcomes.size() == 0) begin
        flag_mismatch("unexpected beat, cur_state", -1, observed.state);
      end else begin
        oldest = pending_outcomes.pop_front();
        if (observed.state !== oldest.state)
          flag_mismatch("cur_state", oldest.state, observed.state);
        if (observed.status !== oldest.status)
          flag_mismatch("status", oldest.status, observed.status);
      end
    end
    if (rst_n && in_valid && in_ready) begin
      predicted = apply_command(in_command, in_target_state, in_symbol, in_next_state,
                                in_capacity);
      pending_outcomes.push_back(row_typed ? row_want : predicted);
    end
    if ((rst_n && in_valid && in_ready) || (rst_n && out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("programmable_fsm_table_engine: mismatch");
    $finish;
  end

  // result side; a long hold is counted out here while the sender keeps offering
  initial begin
    int hold_seen;
    hold_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic offer(input logic [2:0] cmd, input logic [3:0] tgt, input logic [7:0] sym,
                       input logic [3:0] dst, input logic [3:0] cap, input logic typed,
                       input outcome_t want);
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_target_state <= tgt;
    in_symbol       <= sym;
    in_next_state   <= dst;
    in_capacity     <= cap;
    row_typed       <= typed;
    row_want        <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_gaps();
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0);
  endtask

  // mostly a handful of states and keys so that tables fill, overwrite and get walked
  task automatic send_random();
    logic [2:0] cmd;
    logic [3:0] tgt;
    logic [7:0] sym;
    logic [3:0] dst;
    logic [3:0] cap;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 38)      cmd = CMD_STEP;
    else if (pick < 50) cmd = CMD_ADD_STATE;
    else if (pick < 56) cmd = CMD_DEL_STATE;
    else if (pick < 84) cmd = CMD_ADD_EDGE;
    else if (pick < 95) cmd = CMD_DEL_EDGE;
    else                cmd = 3'($urandom_range(CMD_RSVD5, CMD_RSVD7));
    if ($urandom_range(9) < 8) tgt = 4'($urandom_range(5));
    else                       tgt = 4'($urandom);
    if ($urandom_range(9) < 7) sym = symbol_pool[3'($urandom_range(5))];
    else                       sym = 8'($urandom);
    if ($urandom_range(9) < 8) dst = 4'($urandom_range(5));
    else                       dst = 4'($urandom);
    cap = 4'($urandom);
    sender_gaps();
    offer(cmd, tgt, sym, dst, cap, 1'b0, '0);
  endtask

  initial begin
    clear_mirror();
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_command      <= '0;
    in_target_state <= '0;
    in_symbol       <= '0;
    in_next_state   <= '0;
    in_capacity     <= '0;
    row_typed       <= 1'b0;
    row_want        <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++)
      offer(directed_rows[i].cmd, directed_rows[i].tgt, directed_rows[i].sym,
            directed_rows[i].dst, directed_rows[i].cap, directed_rows[i].typed,
            directed_rows[i].want);
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 52; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 52; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 2 && n == 100)
          hold_req++;
        if (n == 200)
          drain_results();
        send_random();
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      mismatches++;
      $display("%0d expected beats never arrived", pending_outcomes.size());
    end
    if (mismatches == 0)
      $display("programmable_fsm_table_engine: match");
    else
      $display("programmable_fsm_table_engine: mismatch");
    $finish;
  end

endmodule
